@@ design/rwtz_pkg.sv @@
// Shared types, register codes and arithmetic helpers for the random walk trial scorer.
// Used by rwtz_accum, rwtz_score and random_walk_trial_zscore_core; no dependencies.
package rwtz_pkg;

    localparam int unsigned LenW    = 10;
    localparam int unsigned SumW    = 13;
    localparam int unsigned ScaleW  = 16;
    localparam int unsigned WalkW   = 14;
    localparam int unsigned ZW      = 16;
    localparam int unsigned WideW   = 16;
    localparam int unsigned ProdW   = 32;
    localparam int unsigned AddrW   = 4;
    localparam int unsigned DataW   = 32;

    localparam logic [LenW-1:0]   TrialLengthReset = LenW'(125);
    localparam logic [ScaleW-1:0] InvRootReset     = ScaleW'(2216);

    typedef enum logic [1:0] {
        REG_TRIAL_LENGTH = 2'd0,
        REG_AC_ENABLE    = 2'd1,
        REG_INV_ROOT     = 2'd2,
        REG_NONE         = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [SumW-1:0] bias_sum;
        logic [SumW-1:0] ac_sum;
        logic [LenW-1:0] len;
        logic            ac_en;
    } trial_t;

    function automatic logic [2:0] ones_low7(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < 7; i++) begin
            n = n + {2'b00, b[i]};
        end
        return n;
    endfunction

    function automatic logic signed [WalkW-1:0] sat_walk(input logic signed [WideW-1:0] w);
        logic signed [WalkW-1:0] r;
        if (w > WideW'(8191)) begin
            r = WalkW'(8191);
        end else if (w < -WideW'(8192)) begin
            r = -WalkW'(8192);
        end else begin
            r = w[WalkW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ZW-1:0] sat_z(input logic signed [ProdW-1:0] p);
        logic signed [ProdW-1:0] q;
        logic signed [ZW-1:0]    r;
        q = p >>> 8;
        if (q > ProdW'(32767)) begin
            r = ZW'(32767);
        end else if (q < -ProdW'(32768)) begin
            r = -ZW'(32768);
        end else begin
            r = q[ZW-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/rwtz_accum.sv @@
// Per-stream ones and byte counters that close a trial when both streams are full.
// Depends on rwtz_pkg.
module rwtz_accum (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     byte_accept,
    input  logic [7:0]               random_byte,
    input  logic [rwtz_pkg::LenW-1:0] trial_length,
    input  logic                     ac_enable,
    output logic                     trial_done,
    output rwtz_pkg::trial_t         trial
);
    import rwtz_pkg::*;

    logic [SumW-1:0] bias_sum_reg, bias_sum_next;
    logic [SumW-1:0] ac_sum_reg, ac_sum_next;
    logic [LenW-1:0] bias_cnt_reg, bias_cnt_next;
    logic [LenW-1:0] ac_cnt_reg, ac_cnt_next;
    logic [SumW-1:0] ones;
    logic [SumW-1:0] bias_sum_add;
    logic [SumW-1:0] ac_sum_add;
    logic [LenW-1:0] bias_cnt_add;
    logic [LenW-1:0] ac_cnt_add;
    logic            bias_full;
    logic            ac_full;
    logic            bias_full_after;
    logic            ac_full_after;

    assign ones      = SumW'(ones_low7(random_byte));
    assign bias_full = bias_cnt_reg >= trial_length;
    assign ac_full   = !ac_enable || (ac_cnt_reg >= trial_length);

    always_comb begin
        bias_sum_add = bias_sum_reg;
        bias_cnt_add = bias_cnt_reg;
        ac_sum_add   = ac_sum_reg;
        ac_cnt_add   = ac_cnt_reg;
        if (random_byte[7]) begin
            if (!bias_full) begin
                bias_sum_add = bias_sum_reg + ones;
                bias_cnt_add = bias_cnt_reg + LenW'(1);
            end
        end else if (!ac_full) begin
            ac_sum_add = ac_sum_reg + ones;
            ac_cnt_add = ac_cnt_reg + LenW'(1);
        end
    end

    assign bias_full_after = bias_cnt_add >= trial_length;
    assign ac_full_after   = !ac_enable || (ac_cnt_add >= trial_length);
    assign trial_done      = byte_accept && bias_full_after && ac_full_after;

    assign trial.bias_sum = bias_sum_add;
    assign trial.ac_sum   = ac_sum_add;
    assign trial.len      = trial_length;
    assign trial.ac_en    = ac_enable;

    always_comb begin
        bias_sum_next = bias_sum_reg;
        bias_cnt_next = bias_cnt_reg;
        ac_sum_next   = ac_sum_reg;
        ac_cnt_next   = ac_cnt_reg;
        if (trial_done) begin
            bias_sum_next = '0;
            bias_cnt_next = '0;
            ac_sum_next   = '0;
            ac_cnt_next   = '0;
        end else if (byte_accept) begin
            bias_sum_next = bias_sum_add;
            bias_cnt_next = bias_cnt_add;
            ac_sum_next   = ac_sum_add;
            ac_cnt_next   = ac_cnt_add;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_sum_reg <= '0;
            bias_cnt_reg <= '0;
            ac_sum_reg   <= '0;
            ac_cnt_reg   <= '0;
        end else begin
            bias_sum_reg <= bias_sum_next;
            bias_cnt_reg <= bias_cnt_next;
            ac_sum_reg   <= ac_sum_next;
            ac_cnt_reg   <= ac_cnt_next;
        end
    end

endmodule

@@ design/rwtz_score.sv @@
// Three-stage pipeline that turns a closed trial into walks and saturated Q8.8 z-scores.
// Depends on rwtz_pkg.
module rwtz_score (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rwtz_pkg::trial_t                  trial,
    input  logic [rwtz_pkg::ScaleW-1:0]       scale,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [rwtz_pkg::WalkW-1:0] bias_walk,
    output logic signed [rwtz_pkg::ZW-1:0]    bias_z,
    output logic signed [rwtz_pkg::WalkW-1:0] ac_walk,
    output logic signed [rwtz_pkg::ZW-1:0]    ac_z
);
    import rwtz_pkg::*;

    logic                     p1_valid_reg;
    trial_t                   p1_trial_reg;
    logic                     p2_valid_reg;
    logic signed [WideW-1:0]  p2_bias_walk_reg;
    logic signed [WideW-1:0]  p2_ac_walk_reg;
    logic signed [ProdW-1:0]  p2_bias_prod_reg;
    logic signed [ProdW-1:0]  p2_ac_prod_reg;
    logic                     out_valid_reg;
    logic signed [WalkW-1:0]  bias_walk_reg;
    logic signed [ZW-1:0]     bias_z_reg;
    logic signed [WalkW-1:0]  ac_walk_reg;
    logic signed [ZW-1:0]     ac_z_reg;

    logic                     out_adv;
    logic                     p2_adv;
    logic                     p1_adv;
    logic [SumW-1:0]          len7;
    logic signed [WideW-1:0]  bias_walk_c;
    logic signed [WideW-1:0]  ac_walk_c;
    logic signed [ProdW-1:0]  bias_prod_c;
    logic signed [ProdW-1:0]  ac_prod_c;
    logic signed [ScaleW:0]   scale_s;

    assign out_adv  = !out_valid_reg || out_ready;
    assign p2_adv   = !p2_valid_reg || out_adv;
    assign p1_adv   = !p1_valid_reg || p2_adv;
    assign in_ready = p1_adv;

    assign len7    = (SumW'(p1_trial_reg.len) << 3) - SumW'(p1_trial_reg.len);
    assign scale_s = $signed({1'b0, scale});

    always_comb begin
        bias_walk_c = $signed({2'b00, p1_trial_reg.bias_sum, 1'b0}) - $signed({3'b000, len7});
        if (p1_trial_reg.ac_en) begin
            ac_walk_c = $signed({2'b00, p1_trial_reg.ac_sum, 1'b0}) - $signed({3'b000, len7});
        end else begin
            ac_walk_c = '0;
        end
        bias_prod_c = ProdW'(bias_walk_c) * ProdW'(scale_s);
        ac_prod_c   = ProdW'(ac_walk_c) * ProdW'(scale_s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (p1_adv) begin
                p1_valid_reg <= in_valid;
            end
            if (p2_adv) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (out_adv) begin
                out_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            p1_trial_reg <= trial;
        end
        if (p2_adv) begin
            p2_bias_walk_reg <= bias_walk_c;
            p2_ac_walk_reg   <= ac_walk_c;
            p2_bias_prod_reg <= bias_prod_c;
            p2_ac_prod_reg   <= ac_prod_c;
        end
        if (out_adv) begin
            bias_walk_reg <= sat_walk(p2_bias_walk_reg);
            bias_z_reg    <= sat_z(p2_bias_prod_reg);
            ac_walk_reg   <= sat_walk(p2_ac_walk_reg);
            ac_z_reg      <= sat_z(p2_ac_prod_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign bias_walk = bias_walk_reg;
    assign bias_z    = bias_z_reg;
    assign ac_walk   = ac_walk_reg;
    assign ac_z      = ac_z_reg;

endmodule

@@ design/random_walk_trial_zscore_core.sv @@
// Top level of the random walk trial scorer: APB register file, counters and scoring pipeline.
// Depends on rwtz_pkg, rwtz_accum and rwtz_score.

// The core takes one random byte per clock cycle while s_ready is high. Bytes with bit 7 set
// feed the bias stream, the rest feed the ac stream, and each stream counts the ones in the
// low seven bits until it holds trial_length bytes. The byte that closes a trial produces
// one result transaction, carrying both walks and their Q8.8 z-scores; the counters clear
// with that byte, so the next byte already starts a new trial. The rate is set by the single
// counter update per byte and by the three-register scoring pipeline, which holds up to
// three results and only stalls the input when all of them wait on m_ready. Registers are
// written through the APB port at offsets 0x0 (trial_length), 0x4 (ac_enable) and 0x8
// (inverse_root_scale) and should be changed only while no transaction is in flight.
module random_walk_trial_zscore_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rwtz_pkg::AddrW-1:0]        paddr,
    input  logic [rwtz_pkg::DataW-1:0]        pwdata,
    output logic [rwtz_pkg::DataW-1:0]        prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_random_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [rwtz_pkg::WalkW-1:0] m_bias_walk,
    output logic signed [rwtz_pkg::ZW-1:0]    m_bias_z,
    output logic signed [rwtz_pkg::WalkW-1:0] m_ac_walk,
    output logic signed [rwtz_pkg::ZW-1:0]    m_ac_z
);
    import rwtz_pkg::*;

    logic [LenW-1:0]   trial_length_reg;
    logic              ac_enable_reg;
    logic [ScaleW-1:0] inv_root_reg;
    reg_index_t        reg_sel;
    logic              reg_write;
    logic              byte_accept;
    logic              trial_done;
    trial_t            trial;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[3:2]);
    assign reg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trial_length_reg <= TrialLengthReset;
            ac_enable_reg    <= 1'b0;
            inv_root_reg     <= InvRootReset;
        end else if (reg_write) begin
            unique case (reg_sel)
                REG_TRIAL_LENGTH: trial_length_reg <= pwdata[LenW-1:0];
                REG_AC_ENABLE:    ac_enable_reg    <= pwdata[0];
                REG_INV_ROOT:     inv_root_reg     <= pwdata[ScaleW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TRIAL_LENGTH: prdata = DataW'(trial_length_reg);
            REG_AC_ENABLE:    prdata = DataW'(ac_enable_reg);
            REG_INV_ROOT:     prdata = DataW'(inv_root_reg);
            default:          prdata = '0;
        endcase
    end

    assign byte_accept = s_valid && s_ready;

    rwtz_accum u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .random_byte  (s_random_byte),
        .trial_length (trial_length_reg),
        .ac_enable    (ac_enable_reg),
        .trial_done   (trial_done),
        .trial        (trial)
    );

    rwtz_score u_score (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (trial_done),
        .in_ready  (s_ready),
        .trial     (trial),
        .scale     (inv_root_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .bias_walk (m_bias_walk),
        .bias_z    (m_bias_z),
        .ac_walk   (m_ac_walk),
        .ac_z      (m_ac_z)
    );

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for random_walk_trial_zscore_core: random bytes in, trial scores out.
// Scores are predicted per accepted byte and compared with every result transaction.
// Depends on rwtz_pkg and the random_walk_trial_zscore_core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rwtz_pkg::*;

    typedef struct packed {
        logic signed [WalkW-1:0] bias_walk;
        logic signed [ZW-1:0]    bias_z;
        logic signed [WalkW-1:0] ac_walk;
        logic signed [ZW-1:0]    ac_z;
    } trial_score_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [AddrW-1:0]         paddr = '0;
    logic [DataW-1:0]         pwdata = '0;
    logic [DataW-1:0]         prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [7:0]               s_random_byte = 8'h00;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [WalkW-1:0]  m_bias_walk;
    logic signed [ZW-1:0]     m_bias_z;
    logic signed [WalkW-1:0]  m_ac_walk;
    logic signed [ZW-1:0]     m_ac_z;

    logic [LenW-1:0]   cfg_trial_length = TrialLengthReset;
    logic              cfg_ac_enable = 1'b0;
    logic [ScaleW-1:0] cfg_inv_root = InvRootReset;

    int bias_ones = 0;
    int bias_bytes = 0;
    int ac_ones = 0;
    int ac_bytes = 0;

    logic [7:0]   byte_queue[$];
    trial_score_t scores_due[$];

    int error_count = 0;
    int sent_items = 0;
    int idle_left = 0;
    int stall_left = 0;
    bit src_calm = 1'b0;
    bit sink_calm = 1'b0;

    random_walk_trial_zscore_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_random_byte (s_random_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bias_walk   (m_bias_walk),
        .m_bias_z      (m_bias_z),
        .m_ac_walk     (m_ac_walk),
        .m_ac_z        (m_ac_z)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int next_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [WalkW-1:0] clip_walk(input int w);
        if (w > 8191) begin
            return WalkW'(8191);
        end else if (w < -8192) begin
            return -WalkW'(8192);
        end
        return WalkW'(w);
    endfunction

    function automatic logic signed [ZW-1:0] zscore(input int w, input logic [ScaleW-1:0] scale);
        longint p;
        longint q;
        p = longint'(w) * longint'({1'b0, scale});
        q = p >>> 8;
        if (q > 32767) begin
            return ZW'(32767);
        end else if (q < -32768) begin
            return -ZW'(32768);
        end
        return ZW'(q);
    endfunction

    task automatic take_byte(input logic [7:0] b);
        int           len;
        int           ones;
        int           w;
        bit           bias_full;
        bit           ac_full;
        trial_score_t score;
        len = (cfg_trial_length < 1023) ? int'(cfg_trial_length) : 1023;
        ones = $countones(b[6:0]);
        bias_full = bias_bytes >= len;
        ac_full = !cfg_ac_enable || ac_bytes >= len;
        if (b[7]) begin
            if (!bias_full) begin
                bias_ones += ones;
                bias_bytes++;
            end
        end else if (!ac_full) begin
            ac_ones += ones;
            ac_bytes++;
        end
        bias_full = bias_bytes >= len;
        ac_full = !cfg_ac_enable || ac_bytes >= len;
        if (bias_full && ac_full) begin
            w = 2 * bias_ones - 7 * len;
            score.bias_walk = clip_walk(w);
            score.bias_z = zscore(w, cfg_inv_root);
            if (cfg_ac_enable) begin
                w = 2 * ac_ones - 7 * len;
                score.ac_walk = clip_walk(w);
                score.ac_z = zscore(w, cfg_inv_root);
            end else begin
                score.ac_walk = '0;
                score.ac_z = '0;
            end
            scores_due.push_back(score);
            bias_ones = 0;
            bias_bytes = 0;
            ac_ones = 0;
            ac_bytes = 0;
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Driver: one byte transaction at a time from byte_queue, with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                take_byte(s_random_byte);
            end
            if (!s_valid || s_ready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_random_byte <= byte_queue.pop_front();
                    idle_left = next_gap(src_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction against the oldest predicted score.
    always @(posedge aclk) begin : score_monitor
        trial_score_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (scores_due.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                             $time, m_bias_walk, m_bias_z, m_ac_walk, m_ac_z);
                end else begin
                    want = scores_due.pop_front();
                    check_field("bias_walk", want.bias_walk, m_bias_walk);
                    check_field("bias_z", want.bias_z, m_bias_z);
                    check_field("ac_walk", want.ac_walk, m_ac_walk);
                    check_field("ac_z", want.ac_z, m_ac_z);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = next_gap(sink_calm);
            end
        end
    end

    task automatic reg_write(input reg_index_t idx, input logic [DataW-1:0] value);
        logic [DataW-1:0] mask;
        logic [DataW-1:0] readback;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrW'(4 * int'(idx));
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TRIAL_LENGTH: begin
                cfg_trial_length = value[LenW-1:0];
                mask = (DataW'(1) << LenW) - 1;
            end
            REG_AC_ENABLE: begin
                cfg_ac_enable = value[0];
                mask = DataW'(1);
            end
            REG_INV_ROOT: begin
                cfg_inv_root = value[ScaleW-1:0];
                mask = (DataW'(1) << ScaleW) - 1;
            end
            default: begin
                mask = '0;
            end
        endcase
        @(posedge aclk);
        psel <= 1'b1;
        paddr <= AddrW'(4 * int'(idx));
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if ((readback & mask) != (value & mask)) begin
            error_count++;
            $display("%0t: register %s readback, expected %0d, actual %0d",
                     $time, idx.name(), value & mask, readback & mask);
        end
    endtask

    task automatic send(input logic [7:0] b);
        byte_queue.push_back(b);
        sent_items++;
    endtask

    task automatic wait_idle();
        do @(posedge aclk); while (byte_queue.size() != 0 || s_valid || scores_due.size() != 0);
        repeat (10) @(posedge aclk);
    endtask

    initial begin : stimulus
        int len;
        int count;
        int bias_pct;
        int style;
        int r;
        logic [6:0] low;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        reg_write(REG_TRIAL_LENGTH, 1);
        reg_write(REG_AC_ENABLE, 1);
        reg_write(REG_INV_ROOT, 32'hFFFF);
        send(8'hFF); send(8'h00); send(8'h80); send(8'h7F);
        send(8'hFF); send(8'hAA); send(8'h55);
        wait_idle();

        reg_write(REG_AC_ENABLE, 0);
        reg_write(REG_INV_ROOT, 0);
        send(8'h00); send(8'hC3);
        wait_idle();

        reg_write(REG_TRIAL_LENGTH, 0);
        reg_write(REG_INV_ROOT, 32'h8000);
        send(8'h00); send(8'hFF); send(8'h80); send(8'h7F);
        wait_idle();

        reg_write(REG_TRIAL_LENGTH, 3);
        reg_write(REG_AC_ENABLE, 1);
        reg_write(REG_INV_ROOT, 1);
        send(8'hFE); send(8'h01); send(8'h81); send(8'h40); send(8'h9F);
        wait_idle();
        reg_write(REG_AC_ENABLE, 0);
        send(8'h2A);
        wait_idle();

        // A long all-ones bias stream cut short by a lower length drives the walk past its range.
        reg_write(REG_TRIAL_LENGTH, 1023);
        reg_write(REG_AC_ENABLE, 1);
        reg_write(REG_INV_ROOT, 32'hFFFF);
        src_calm = 1'b1;
        repeat (600) send(8'hFF);
        wait_idle();
        reg_write(REG_TRIAL_LENGTH, 1);
        send(8'h00);
        wait_idle();

        while (sent_items < 1150) begin
            src_calm = ($urandom_range(0, 5) == 0);
            sink_calm = ($urandom_range(0, 6) == 0);
            r = $urandom_range(0, 99);
            if (r < 6) begin
                len = 0;
            end else if (r < 60) begin
                len = $urandom_range(1, 6);
            end else if (r < 88) begin
                len = $urandom_range(7, 20);
            end else begin
                len = $urandom_range(21, 60);
            end
            reg_write(REG_TRIAL_LENGTH, len);
            if ($urandom_range(0, 1) == 1) begin
                reg_write(REG_AC_ENABLE, $urandom_range(0, 1));
            end
            if ($urandom_range(0, 9) < 4) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    reg_write(REG_INV_ROOT, 0);
                end else if (r < 30) begin
                    reg_write(REG_INV_ROOT, 32'hFFFF);
                end else begin
                    reg_write(REG_INV_ROOT, $urandom_range(0, 65535));
                end
            end
            r = $urandom_range(0, 2);
            bias_pct = (r == 0) ? 50 : (r == 1) ? 85 : 15;
            style = $urandom_range(0, 9);
            count = $urandom_range(6, 30);
            repeat (count) begin
                if (style < 6) begin
                    low = 7'($urandom);
                end else if (style < 8) begin
                    low = 7'h7F;
                end else begin
                    low = 7'h00;
                end
                send({($urandom_range(0, 99) < bias_pct), low});
            end
            wait_idle();
        end

        if (error_count == 0 && scores_due.size() == 0) begin
            $display("** random_walk_trial_zscore_core: PASSED **");
        end else begin
            $display("** random_walk_trial_zscore_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("** random_walk_trial_zscore_core: FAILED **");
        $finish;
    end

endmodule
